/* rtl/round_robin_task_scheduler_assert.svh */
// Assertion macros for the round-robin task scheduler.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
`define RRTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");
`define RRTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");
`else
`define RRTS_ASSERT_NOW(label, ante, cons)
`define RRTS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/rrts_pkg.sv */
// Shared types and constants for the round-robin task scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
package rrts_pkg;

    localparam int NUM_SLOTS  = 32;
    localparam int IDX_W      = $clog2(NUM_SLOTS);
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int TASK_ID_W  = 5;
    localparam int REQ_W      = 3;
    localparam int PRIO_W     = 3;
    localparam int STATE_W    = 2;
    localparam int KEY_W      = 16;
    localparam int QUANT_W    = 8;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [QUANT_W-1:0] QUANTUM_MS_RST = 8'd2;
    localparam logic [PRIO_W-1:0]  SLOT0_PRIO_RST = 3'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK      = 3'd0,
        REQ_CREATE    = 3'd1,
        REQ_SET_STATE = 3'd2,
        REQ_UNBLOCK   = 3'd3,
        REQ_ISSUE_KEY = 3'd4
    } req_t;

    typedef enum logic [STATE_W-1:0] {
        ST_STOP  = 2'd0,
        ST_WAIT  = 2'd1,
        ST_RUN   = 2'd2,
        ST_BLOCK = 2'd3
    } slot_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUANTUM_MS       = 1'b0,
        CFG_INITIAL_PRIORITY = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ADDR_CUR  = 2'd0,
        ADDR_SCAN = 2'd1,
        ADDR_NEXT = 2'd2
    } addr_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEMOTE,
        S_TAKE,
        S_REBUILD,
        S_RETAKE,
        S_SELECT,
        S_CREATE,
        S_UNBLOCK,
        S_SET_STATE,
        S_ISSUE_KEY,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic      latch_in;
        addr_sel_t addr_sel;
        logic      demote;
        logic      take;
        logic      rebuild_start;
        logic      rebuild_step;
        logic      keep_current;
        logic      select_next;
        logic      scan_start;
        logic      create_step;
        logic      unblock_step;
        logic      set_state;
        logic      issue_key;
        logic      stage_clear;
        logic      load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic snap_avail;
        logic scan_last;
        logic create_hit;
        logic unblock_hit;
    } dp_status_t;

    function automatic logic [TASK_ID_W-1:0] to_task_id(input logic [IDX_W-1:0] idx);
        logic [TASK_ID_W+IDX_W-1:0] wide;
        wide = {{TASK_ID_W{1'b0}}, idx};
        return wide[TASK_ID_W-1:0];
    endfunction

endpackage

/* rtl/rrts_ctrl.sv */
// Controller state machine of the round-robin task scheduler.
// Depends on rrts_pkg; drives the datapath commands and the channel handshakes.
module rrts_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rrts_pkg::REQ_W-1:0]     req_type,
    output logic                           out_valid,
    input  logic                           out_ready,
    input  rrts_pkg::dp_status_t           status,
    output rrts_pkg::dp_cmd_t              cmd
);
    import rrts_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.addr_sel   = ADDR_SCAN;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    case (req_t'(req_type))
                        REQ_TICK:      state_next = S_DEMOTE;
                        REQ_CREATE:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_CREATE;
                        end
                        REQ_SET_STATE: state_next = S_SET_STATE;
                        REQ_UNBLOCK:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_UNBLOCK;
                        end
                        REQ_ISSUE_KEY: state_next = S_ISSUE_KEY;
                        default:
                        begin
                            cmd.stage_clear = 1'b1;
                            state_next      = S_FINISH;
                        end
                    endcase
                end
            end
            S_DEMOTE:
            begin
                cmd.addr_sel = ADDR_CUR;
                cmd.demote   = 1'b1;
                state_next   = S_TAKE;
            end
            S_TAKE:
            begin
                if (status.snap_avail)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_SELECT;
                end
                else
                begin
                    cmd.rebuild_start = 1'b1;
                    state_next        = S_REBUILD;
                end
            end
            S_REBUILD:
            begin
                cmd.addr_sel     = ADDR_SCAN;
                cmd.rebuild_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_RETAKE;
                end
            end
            S_RETAKE:
            begin
                if (status.snap_avail)
                begin
                    cmd.take = 1'b1;
                end
                else
                begin
                    cmd.keep_current = 1'b1;
                end
                state_next = S_SELECT;
            end
            S_SELECT:
            begin
                cmd.addr_sel    = ADDR_NEXT;
                cmd.select_next = 1'b1;
                state_next      = S_FINISH;
            end
            S_CREATE:
            begin
                cmd.addr_sel    = ADDR_SCAN;
                cmd.create_step = 1'b1;
                if (status.create_hit)
                begin
                    state_next = S_FINISH;
                end
                else if (status.scan_last)
                begin
                    cmd.stage_clear = 1'b1;
                    state_next      = S_FINISH;
                end
            end
            S_UNBLOCK:
            begin
                cmd.addr_sel     = ADDR_SCAN;
                cmd.unblock_step = 1'b1;
                if (status.unblock_hit)
                begin
                    state_next = S_FINISH;
                end
                else if (status.scan_last)
                begin
                    cmd.stage_clear = 1'b1;
                    state_next      = S_FINISH;
                end
            end
            S_SET_STATE:
            begin
                cmd.addr_sel  = ADDR_CUR;
                cmd.set_state = 1'b1;
                state_next    = S_FINISH;
            end
            S_ISSUE_KEY:
            begin
                cmd.issue_key = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/rrts_datapath.sv */
// Datapath of the round-robin task scheduler: slot table, snapshot list,
// counters, configuration and result registers. Depends on rrts_pkg.
module rrts_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rrts_pkg::dp_cmd_t                 cmd,
    output rrts_pkg::dp_status_t              status,
    input  logic                              cfg_write,
    input  logic [rrts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrts_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [rrts_pkg::PRIO_W-1:0]       priority_req,
    input  logic [rrts_pkg::STATE_W-1:0]      new_state,
    input  logic [rrts_pkg::KEY_W-1:0]        blocker_key,
    output logic [rrts_pkg::TASK_ID_W-1:0]    task_id,
    output logic                              ok,
    output logic [rrts_pkg::DELAY_W-1:0]      delay_ms,
    output logic [rrts_pkg::KEY_W-1:0]        issued_key
);
    import rrts_pkg::*;

    slot_state_t            slot_state_reg [NUM_SLOTS];
    logic [PRIO_W-1:0]      slot_prio_reg  [NUM_SLOTS];
    logic [KEY_W-1:0]       slot_key_reg   [NUM_SLOTS];
    logic [IDX_W-1:0]       snap_list_reg  [NUM_SLOTS];
    logic [CNT_W-1:0]       snap_len_reg;
    logic [CNT_W-1:0]       snap_pos_reg;
    logic [IDX_W-1:0]       cur_reg;
    logic [IDX_W-1:0]       next_reg;
    logic [IDX_W-1:0]       scan_reg;
    logic [KEY_W-1:0]       next_key_reg;
    logic [QUANT_W-1:0]     quantum_reg;

    logic [PRIO_W-1:0]      in_prio_reg;
    slot_state_t            in_state_reg;
    logic [KEY_W-1:0]       in_key_reg;

    logic [TASK_ID_W-1:0]   stage_id_reg;
    logic                   stage_ok_reg;
    logic [DELAY_W-1:0]     stage_delay_reg;
    logic [KEY_W-1:0]       stage_key_reg;
    logic [TASK_ID_W-1:0]   task_id_reg;
    logic                   ok_reg;
    logic [DELAY_W-1:0]     delay_reg;
    logic [KEY_W-1:0]       issued_reg;

    logic [IDX_W-1:0]          rd_addr;
    slot_state_t               state_rd;
    logic [PRIO_W-1:0]         prio_rd;
    logic [KEY_W-1:0]          key_rd;
    logic                      state_we;
    slot_state_t               state_wdata;
    logic                      prio_we;
    logic                      key_we;
    logic [KEY_W-1:0]          key_wdata;
    logic                      snap_we;
    logic [KEY_W-1:0]          key_issue;
    logic [PRIO_W+QUANT_W-1:0] quantum_product;

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_CUR:  rd_addr = cur_reg;
            ADDR_NEXT: rd_addr = next_reg;
            default:   rd_addr = scan_reg;
        endcase
    end

    assign state_rd = slot_state_reg[rd_addr];
    assign prio_rd  = slot_prio_reg[rd_addr];
    assign key_rd   = slot_key_reg[rd_addr];

    assign status.snap_avail  = (snap_pos_reg < snap_len_reg);
    assign status.scan_last   = (scan_reg == IDX_W'(NUM_SLOTS - 1));
    assign status.create_hit  = (state_rd == ST_STOP);
    assign status.unblock_hit = (state_rd == ST_BLOCK) && (key_rd == in_key_reg);

    // The product of a 3-bit priority and an 8-bit quantum never reaches
    // the 16-bit saturation limit, so a zero extension is exact.
    assign quantum_product = prio_rd * quantum_reg;
    assign key_issue       = (next_key_reg == '0) ? KEY_W'(1) : next_key_reg;

    always_comb
    begin
        state_we    = 1'b0;
        state_wdata = ST_WAIT;
        prio_we     = 1'b0;
        key_we      = 1'b0;
        key_wdata   = '0;
        if (cmd.demote && (state_rd == ST_RUN))
        begin
            state_we = 1'b1;
        end
        if (cmd.select_next)
        begin
            state_we    = 1'b1;
            state_wdata = ST_RUN;
        end
        if (cmd.create_step && status.create_hit)
        begin
            state_we = 1'b1;
            prio_we  = 1'b1;
        end
        if (cmd.unblock_step && status.unblock_hit)
        begin
            state_we = 1'b1;
            key_we   = 1'b1;
        end
        if (cmd.set_state)
        begin
            state_we    = 1'b1;
            state_wdata = in_state_reg;
            if (in_state_reg == ST_BLOCK)
            begin
                key_we    = 1'b1;
                key_wdata = in_key_reg;
            end
        end
    end

    assign snap_we = cmd.rebuild_step && (state_rd == ST_WAIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_state_reg[i] <= ST_STOP;
                slot_prio_reg[i]  <= '0;
                snap_list_reg[i]  <= '0;
            end
            slot_state_reg[0] <= ST_WAIT;
            slot_prio_reg[0]  <= SLOT0_PRIO_RST;
            snap_len_reg      <= CNT_W'(1);
            snap_pos_reg      <= '0;
            cur_reg           <= '0;
            next_reg          <= '0;
            scan_reg          <= '0;
            next_key_reg      <= KEY_W'(1);
            quantum_reg       <= QUANTUM_MS_RST;
        end
        else
        begin
            if (state_we)
            begin
                slot_state_reg[rd_addr] <= state_wdata;
            end
            if (prio_we)
            begin
                slot_prio_reg[rd_addr] <= in_prio_reg;
            end
            if (snap_we)
            begin
                snap_list_reg[snap_len_reg[IDX_W-1:0]] <= scan_reg;
            end

            if (cmd.rebuild_start)
            begin
                snap_len_reg <= '0;
            end
            else if (snap_we)
            begin
                snap_len_reg <= snap_len_reg + CNT_W'(1);
            end

            if (cmd.rebuild_start)
            begin
                snap_pos_reg <= '0;
            end
            else if (cmd.take)
            begin
                snap_pos_reg <= snap_pos_reg + CNT_W'(1);
            end

            if (cmd.take)
            begin
                next_reg <= snap_list_reg[snap_pos_reg[IDX_W-1:0]];
            end
            else if (cmd.keep_current)
            begin
                next_reg <= cur_reg;
            end

            if (cmd.select_next)
            begin
                cur_reg <= next_reg;
            end

            if (cmd.scan_start || cmd.rebuild_start)
            begin
                scan_reg <= '0;
            end
            else if (cmd.rebuild_step
                     || (cmd.create_step && !status.create_hit)
                     || (cmd.unblock_step && !status.unblock_hit))
            begin
                scan_reg <= scan_reg + IDX_W'(1);
            end

            if (cmd.issue_key)
            begin
                next_key_reg <= key_issue + KEY_W'(1);
            end

            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_QUANTUM_MS:
                    begin
                        quantum_reg <= cfg_data[QUANT_W-1:0];
                    end
                    CFG_INITIAL_PRIORITY:
                    begin
                        // No register is kept for this index; slot zero takes its priority
                        // of one from reset, so a written value is never seen.
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            slot_key_reg[rd_addr] <= key_wdata;
        end

        if (cmd.latch_in)
        begin
            in_prio_reg  <= priority_req;
            in_state_reg <= slot_state_t'(new_state);
            in_key_reg   <= blocker_key;
        end

        if (cmd.stage_clear)
        begin
            stage_id_reg    <= '0;
            stage_ok_reg    <= 1'b0;
            stage_delay_reg <= '0;
            stage_key_reg   <= '0;
        end
        else if (cmd.select_next)
        begin
            stage_id_reg    <= to_task_id(next_reg);
            stage_ok_reg    <= 1'b1;
            stage_delay_reg <= DELAY_W'(quantum_product);
            stage_key_reg   <= '0;
        end
        else if ((cmd.create_step && status.create_hit)
                 || (cmd.unblock_step && status.unblock_hit))
        begin
            stage_id_reg    <= to_task_id(scan_reg);
            stage_ok_reg    <= 1'b1;
            stage_delay_reg <= '0;
            stage_key_reg   <= '0;
        end
        else if (cmd.set_state)
        begin
            stage_id_reg    <= to_task_id(cur_reg);
            stage_ok_reg    <= 1'b1;
            stage_delay_reg <= '0;
            stage_key_reg   <= '0;
        end
        else if (cmd.issue_key)
        begin
            stage_id_reg    <= '0;
            stage_ok_reg    <= 1'b1;
            stage_delay_reg <= '0;
            stage_key_reg   <= key_issue;
        end

        if (cmd.load_out)
        begin
            task_id_reg <= stage_id_reg;
            ok_reg      <= stage_ok_reg;
            delay_reg   <= stage_delay_reg;
            issued_reg  <= stage_key_reg;
        end
    end

    assign task_id    = task_id_reg;
    assign ok         = ok_reg;
    assign delay_ms   = delay_reg;
    assign issued_key = issued_reg;

endmodule

/* rtl/round_robin_task_scheduler.sv */
// Flow: a tick demotes the running slot and takes the next one from the snapshot, which is
// first rebuilt by a walk over all 32 slots when used up; create and unblock scan the slots.
// Setting the current state or issuing a key needs no scan, nor does an unknown request.
// One request at a time: the next is accepted in the cycle after the result is
// registered; the slot scan in the datapath sets the long cases. Reset is asynchronous.
// Top level: joins rrts_ctrl and rrts_datapath; depends on rrts_pkg and the assertion header.
`include "round_robin_task_scheduler_assert.svh"

module round_robin_task_scheduler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rrts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrts_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rrts_pkg::REQ_W-1:0]        req_type,
    input  logic [rrts_pkg::PRIO_W-1:0]       priority_req,
    input  logic [rrts_pkg::STATE_W-1:0]      new_state,
    input  logic [rrts_pkg::KEY_W-1:0]        blocker_key,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rrts_pkg::TASK_ID_W-1:0]    task_id,
    output logic                              ok,
    output logic [rrts_pkg::DELAY_W-1:0]      delay_ms,
    output logic [rrts_pkg::KEY_W-1:0]        issued_key
);
    import rrts_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rrts_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .priority_req (priority_req),
        .new_state    (new_state),
        .blocker_key  (blocker_key),
        .task_id      (task_id),
        .ok           (ok),
        .delay_ms     (delay_ms),
        .issued_key   (issued_key)
    );

    `RRTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `RRTS_ASSERT_NOW(a_load_when_free, cmd.load_out, !out_valid || out_ready)
    `RRTS_ASSERT_NOW(a_fail_is_quiet, out_valid && !ok, task_id == '0 && delay_ms == '0)
    `RRTS_ASSERT_NOW(a_key_implies_ok, out_valid && (issued_key != '0), ok)

endmodule

/* dv/round_robin_task_scheduler_test.sv */
// Self-checking testbench for the round-robin task scheduler.
// Keeps its own scheduler model, drives request words under random flow control and
// checks every result word; depends on rrts_pkg and the round_robin_task_scheduler top.
module round_robin_task_scheduler_test;

    import rrts_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int KEY_RUN_WORDS = 40;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [PRIO_W-1:0]  prio;
        logic [STATE_W-1:0] nstate;
        logic [KEY_W-1:0]   key;
    } req_word_t;

    typedef struct packed {
        logic [TASK_ID_W-1:0] task_id;
        logic                 ok;
        logic [DELAY_W-1:0]   delay;
        logic [KEY_W-1:0]     issued;
    } sched_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_QUANTUM_MS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [REQ_W-1:0]      req_type = '0;
    logic [PRIO_W-1:0]     priority_req = '0;
    logic [STATE_W-1:0]    new_state = '0;
    logic [KEY_W-1:0]      blocker_key = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [TASK_ID_W-1:0]  task_id;
    logic                  ok;
    logic [DELAY_W-1:0]    delay_ms;
    logic [KEY_W-1:0]      issued_key;

    round_robin_task_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .priority_req (priority_req),
        .new_state    (new_state),
        .blocker_key  (blocker_key),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .task_id      (task_id),
        .ok           (ok),
        .delay_ms     (delay_ms),
        .issued_key   (issued_key)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Scheduler model state.
    slot_state_t          tcb_state [NUM_SLOTS];
    logic [PRIO_W-1:0]    tcb_prio [NUM_SLOTS];
    logic [KEY_W-1:0]     tcb_key [NUM_SLOTS];
    logic [IDX_W-1:0]     ready_list [NUM_SLOTS];
    int                   ready_len;
    int                   ready_pos;
    logic [IDX_W-1:0]     cur_slot;
    logic [KEY_W-1:0]     key_ctr;
    logic [QUANT_W-1:0]   quantum_reg;
    logic [PRIO_W-1:0]    init_prio_reg;

    req_word_t            pending_q [$];
    sched_result_t        sched_expect_q [$];
    req_word_t            cur_word;
    req_word_t            drv_word;
    sched_result_t        drv_result;
    sched_result_t        mon_want;

    int                   burst_left = 0;
    int                   gap_left = 0;
    bit                   no_gaps = 1'b0;
    int                   rx_ready_pct = 100;
    bit                   hold_arm = 1'b0;
    bit                   hold_done = 1'b0;
    int                   hold_left = 0;
    int                   idle_cycles = 0;

    int                   err_cnt = 0;
    int unsigned          n_checked = 0;
    int unsigned          n_ticks = 0;
    int unsigned          n_full = 0;
    int unsigned          n_unblock_hit = 0;
    int unsigned          key_wraps = 0;

    function automatic void rebuild_ready_list();
        ready_len = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (tcb_state[i] == ST_WAIT)
            begin
                ready_list[ready_len] = IDX_W'(i);
                ready_len++;
            end
        end
        ready_pos = 0;
    endfunction

    function automatic bit take_ready(output logic [IDX_W-1:0] idx);
        idx = '0;
        if (ready_pos >= ready_len || ready_pos >= NUM_SLOTS)
            return 1'b0;
        idx = ready_list[ready_pos];
        ready_pos++;
        return 1'b1;
    endfunction

    function automatic void sched_reset();
        quantum_reg = QUANTUM_MS_RST;
        init_prio_reg = SLOT0_PRIO_RST;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tcb_state[i] = ST_STOP;
            tcb_prio[i] = '0;
            tcb_key[i] = '0;
            ready_list[i] = '0;
        end
        tcb_state[0] = ST_WAIT;
        tcb_prio[0] = init_prio_reg;
        cur_slot = '0;
        key_ctr = 16'd1;
        rebuild_ready_list();
    endfunction

    function automatic sched_result_t sched_step(input req_word_t w);
        sched_result_t r;
        logic [IDX_W-1:0] nxt;
        int unsigned prod;
        bit found;
        r = '0;
        found = 1'b0;
        case (w.req)
            REQ_TICK:
            begin
                if (tcb_state[cur_slot] == ST_RUN)
                    tcb_state[cur_slot] = ST_WAIT;
                if (!take_ready(nxt))
                begin
                    rebuild_ready_list();
                    if (!take_ready(nxt))
                        nxt = cur_slot;
                end
                tcb_state[nxt] = ST_RUN;
                cur_slot = nxt;
                prod = 32'(tcb_prio[nxt]) * 32'(quantum_reg);
                if (prod > 32'hFFFF)
                    prod = 32'hFFFF;
                r.delay = DELAY_W'(prod);
                r.task_id = TASK_ID_W'(nxt);
                r.ok = 1'b1;
            end
            REQ_CREATE:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!found && tcb_state[i] == ST_STOP)
                    begin
                        tcb_prio[i] = w.prio;
                        tcb_state[i] = ST_WAIT;
                        r.task_id = TASK_ID_W'(i);
                        r.ok = 1'b1;
                        found = 1'b1;
                    end
                end
            end
            REQ_SET_STATE:
            begin
                tcb_state[cur_slot] = slot_state_t'(w.nstate);
                if (w.nstate == ST_BLOCK)
                    tcb_key[cur_slot] = w.key;
                r.task_id = TASK_ID_W'(cur_slot);
                r.ok = 1'b1;
            end
            REQ_UNBLOCK:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!found && tcb_key[i] == w.key && tcb_state[i] == ST_BLOCK)
                    begin
                        tcb_key[i] = '0;
                        tcb_state[i] = ST_WAIT;
                        r.task_id = TASK_ID_W'(i);
                        r.ok = 1'b1;
                        found = 1'b1;
                    end
                end
            end
            REQ_ISSUE_KEY:
            begin
                if (key_ctr == '0)
                begin
                    key_ctr = 16'd1;
                    key_wraps++;
                end
                r.issued = key_ctr;
                key_ctr = key_ctr + 16'd1;
                r.ok = 1'b1;
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic req_word_t mk(input logic [REQ_W-1:0] rq, input logic [PRIO_W-1:0] p,
                                     input logic [STATE_W-1:0] s, input logic [KEY_W-1:0] k);
        req_word_t w;
        w.req = rq;
        w.prio = p;
        w.nstate = s;
        w.key = k;
        return w;
    endfunction

    function automatic logic [KEY_W-1:0] pool_key();
        if ($urandom_range(0, 3) != 0)
            return KEY_W'($urandom_range(0, 7));
        return KEY_W'($urandom);
    endfunction

    // Driver: offers request words in bursts and updates the model on each accepted word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                drv_result = sched_step(cur_word);
                sched_expect_q.push_back(drv_result);
                if (cur_word.req == REQ_TICK)
                    n_ticks++;
                if (cur_word.req == REQ_CREATE && !drv_result.ok)
                    n_full++;
                if (cur_word.req == REQ_UNBLOCK && drv_result.ok)
                    n_unblock_hit++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    drv_word = pending_q.pop_front();
                    cur_word <= drv_word;
                    req_type <= drv_word.req;
                    priority_req <= drv_word.prio;
                    new_state <= drv_word.nstate;
                    blocker_key <= drv_word.key;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        if (no_gaps || $urandom_range(0, 3) == 0)
                            gap_left <= 0;
                        else
                            gap_left <= $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off once it is armed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_arm && !hold_done && out_valid)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) < rx_ready_pct);
        end
    end

    // Monitor: compares each accepted result word with the oldest expected word.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (sched_expect_q.size() == 0)
            begin
                $error("result word with nothing expected: task_id %0d ok %0d", task_id, ok);
                err_cnt++;
            end
            else
            begin
                mon_want = sched_expect_q.pop_front();
                n_checked++;
                if (task_id !== mon_want.task_id)
                begin
                    $error("task_id expected %0d actual %0d", mon_want.task_id, task_id);
                    err_cnt++;
                end
                if (ok !== mon_want.ok)
                begin
                    $error("ok expected %0d actual %0d", mon_want.ok, ok);
                    err_cnt++;
                end
                if (delay_ms !== mon_want.delay)
                begin
                    $error("delay_ms expected %0d actual %0d", mon_want.delay, delay_ms);
                    err_cnt++;
                end
                if (issued_key !== mon_want.issued)
                begin
                    $error("issued_key expected %0d actual %0d", mon_want.issued, issued_key);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_QUANTUM_MS)
            quantum_reg = data;
        else
            init_prio_reg = data[PRIO_W-1:0];
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || in_valid || sched_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic fill_random(input int n, input int wt, input int wc, input int ws,
                               input int wu, input int wi, input int wx);
        req_word_t w;
        int total;
        int r;
        total = wt + wc + ws + wu + wi + wx;
        @(negedge clk);
        for (int k = 0; k < n; k++)
        begin
            w.req = REQ_W'($urandom);
            w.prio = PRIO_W'($urandom);
            w.nstate = STATE_W'($urandom);
            w.key = KEY_W'($urandom);
            r = $urandom_range(0, total - 1);
            if (r < wt)
            begin
                w.req = REQ_TICK;
            end
            else if (r < wt + wc)
            begin
                w.req = REQ_CREATE;
                w.prio = ($urandom_range(0, 9) == 0) ? 3'd0 : PRIO_W'($urandom_range(1, 7));
            end
            else if (r < wt + wc + ws)
            begin
                w.req = REQ_SET_STATE;
                r = $urandom_range(0, 9);
                if (r < 4)
                    w.nstate = ST_BLOCK;
                else if (r < 6)
                    w.nstate = ST_STOP;
                else if (r < 8)
                    w.nstate = ST_RUN;
                else
                    w.nstate = ST_WAIT;
                w.key = pool_key();
            end
            else if (r < wt + wc + ws + wu)
            begin
                w.req = REQ_UNBLOCK;
                w.key = pool_key();
            end
            else if (r < wt + wc + ws + wu + wi)
            begin
                w.req = REQ_ISSUE_KEY;
            end
            else
            begin
                w.req = REQ_W'($urandom_range(5, 7));
            end
            pending_q.push_back(w);
        end
    endtask

    initial
    begin
        sched_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed words, starting from the reset configuration.
        @(negedge clk);
        pending_q.push_back(mk(REQ_TICK, 3'd0, 2'd0, 16'h0000));
        pending_q.push_back(mk(REQ_SET_STATE, 3'd0, ST_STOP, 16'h0000));
        pending_q.push_back(mk(REQ_TICK, 3'd0, 2'd0, 16'h0000));
        pending_q.push_back(mk(REQ_SET_STATE, 3'd0, ST_BLOCK, 16'h0000));
        pending_q.push_back(mk(REQ_UNBLOCK, 3'd0, 2'd0, 16'h0000));
        pending_q.push_back(mk(REQ_UNBLOCK, 3'd0, 2'd0, 16'h0000));
        pending_q.push_back(mk(REQ_CREATE, 3'd7, 2'd0, 16'h0000));
        pending_q.push_back(mk(REQ_CREATE, 3'd0, 2'd0, 16'h0000));
        pending_q.push_back(mk(REQ_TICK, 3'd0, 2'd0, 16'h0000));
        pending_q.push_back(mk(REQ_TICK, 3'd0, 2'd0, 16'h0000));
        pending_q.push_back(mk(REQ_TICK, 3'd0, 2'd0, 16'h0000));
        pending_q.push_back(mk(REQ_SET_STATE, 3'd0, ST_BLOCK, 16'hFFFF));
        pending_q.push_back(mk(REQ_TICK, 3'd0, 2'd0, 16'h0000));
        pending_q.push_back(mk(REQ_UNBLOCK, 3'd0, 2'd0, 16'h1234));
        pending_q.push_back(mk(REQ_UNBLOCK, 3'd0, 2'd0, 16'hFFFF));
        pending_q.push_back(mk(REQ_SET_STATE, 3'd0, ST_RUN, 16'h5555));
        pending_q.push_back(mk(REQ_SET_STATE, 3'd0, ST_WAIT, 16'hAAAA));
        pending_q.push_back(mk(REQ_ISSUE_KEY, 3'd0, 2'd0, 16'h0000));
        pending_q.push_back(mk(REQ_ISSUE_KEY, 3'd7, 2'd3, 16'hFFFF));
        pending_q.push_back(mk(3'd5, 3'd7, 2'd3, 16'hFFFF));
        pending_q.push_back(mk(3'd6, PRIO_W'($urandom), STATE_W'($urandom), KEY_W'($urandom)));
        pending_q.push_back(mk(3'd7, PRIO_W'($urandom), STATE_W'($urandom), KEY_W'($urandom)));
        pending_q.push_back(mk(REQ_CREATE, 3'd7, 2'd3, 16'hFFFF));
        pending_q.push_back(mk(REQ_TICK, 3'd7, 2'd3, 16'hFFFF));
        drain();

        // Create-heavy mix fills the table so that creates are refused.
        write_cfg(CFG_QUANTUM_MS, 8'd255);
        write_cfg(CFG_INITIAL_PRIORITY, 8'd7);
        rx_ready_pct = 70;
        fill_random(300, 25, 45, 15, 10, 3, 2);
        drain();

        // Mixed traffic with one long receiver hold-off while words keep coming.
        write_cfg(CFG_QUANTUM_MS, 8'd1);
        write_cfg(CFG_INITIAL_PRIORITY, 8'd1);
        rx_ready_pct = 100;
        fill_random(300, 35, 15, 25, 20, 3, 2);
        @(posedge clk);
        hold_arm <= 1'b1;
        drain();

        write_cfg(CFG_QUANTUM_MS, 8'd0);
        write_cfg(CFG_INITIAL_PRIORITY, 8'd4);
        rx_ready_pct = 40;
        fill_random(250, 35, 15, 25, 20, 3, 2);
        drain();

        write_cfg(CFG_QUANTUM_MS, CFG_DATA_W'($urandom_range(1, 254)));
        write_cfg(CFG_INITIAL_PRIORITY, CFG_DATA_W'($urandom_range(1, 7)));
        rx_ready_pct = 85;
        fill_random(400, 45, 10, 30, 12, 2, 1);
        drain();

        write_cfg(CFG_QUANTUM_MS, 8'd170);
        write_cfg(CFG_INITIAL_PRIORITY, 8'd3);
        rx_ready_pct = 60;
        fill_random(350, 30, 20, 25, 20, 3, 2);
        drain();

        // Back-to-back key requests and a short mix with no idling on either side.
        write_cfg(CFG_QUANTUM_MS, 8'd85);
        rx_ready_pct = 100;
        no_gaps = 1'b1;
        @(negedge clk);
        for (int k = 0; k < KEY_RUN_WORDS; k++)
            pending_q.push_back(mk(REQ_ISSUE_KEY, PRIO_W'($urandom), STATE_W'($urandom),
                                   KEY_W'($urandom)));
        fill_random(40, 40, 15, 25, 15, 3, 2);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sched_expect_q.size() != 0)
        begin
            $error("%0d expected result words never arrived", sched_expect_q.size());
            err_cnt++;
        end
        $display("tb: %0d result words checked: %0d ticks, %0d creates refused, %0d unblocks",
                 n_checked, n_ticks, n_full, n_unblock_hit);
        $display("tb: six quantum settings including 0 and 255, key counter wrapped %0d time(s)",
                 key_wraps);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
